@@ hw/rtl/ftps_pkg.sv @@
// Shared defaults and percentile constants for the frame time statistics unit.
`default_nettype none
package ftps_pkg;

  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_TIME_BITS   = 24;
  localparam int PCT_NUM         = 4;
  localparam int PCT_K_W         = 7;
  localparam int PCT_DIVISOR     = 100;
  // ceil(2^32 / PCT_DIVISOR); exact quotient for dividends below 2^30
  localparam int PCT_RECIP_SH    = 32;
  localparam int PCT_RECIP_W     = 26;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(42949673);

  function automatic logic [PCT_K_W-1:0] pct_k(input logic [1:0] p);
    logic [PCT_K_W-1:0] k;
    case (p)
      2'd0:    k = PCT_K_W'(50);
      2'd1:    k = PCT_K_W'(90);
      2'd2:    k = PCT_K_W'(95);
      2'd3:    k = PCT_K_W'(99);
      default: k = PCT_K_W'(50);
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/frame_time_percentile_stats_unit.sv @@
// Frame time statistics: sample store, in-memory insertion sort, mean and percentile pick.
//
//   channel | dir | fields
//   in_     | in  | tdata: frame_time_us; tlast: last
//   out_    | out | tdata: n_frames, mean_us, max_us, min_us, p50..p99_us, overflow
//
// Samples load at one per cycle into a one-write, one-read memory. After the closing
// transaction the store is insertion sorted in place. The mean takes a restoring divider
// of TIME_BITS+clog2(MAX_SAMPLES+1) steps; each percentile index takes a multiply and a
// reciprocal multiply, then one read. Reset is synchronous; the store needs no clearing.
// A result waits in the output register while the next set loads; a second result holds
// in_tready low.
`default_nettype none
module frame_time_percentile_stats_unit
  import ftps_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // frame_time_us
  input  wire logic [((TIME_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // n_frames, mean_us, max_us, min_us, p50_us, p90_us, p95_us, p99_us, overflow
  output logic [((($clog2(MAX_SAMPLES+1))+7*TIME_BITS+1+7)/8)*8-1:0] out_tdata
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES+1);
  localparam int AW      = $clog2(MAX_SAMPLES);
  localparam int SUM_W   = TIME_BITS + CNT_W;
  localparam int DV_W    = (CNT_W > PCT_K_W) ? CNT_W : PCT_K_W;
  localparam int STEP_W  = $clog2(SUM_W+1);
  localparam int OUT_RAW = CNT_W + 7*TIME_BITS + 1;
  localparam int OUT_W   = ((OUT_RAW+7)/8)*8;
  localparam int PROD_W  = CNT_W + PCT_K_W;
  localparam int QW      = PROD_W + PCT_RECIP_W;

  typedef enum logic [9:0] {
    S_LOAD = 10'b0000000001,
    S_SCHK = 10'b0000000010,
    S_RI   = 10'b0000000100,
    S_VI   = 10'b0000001000,
    S_CMP  = 10'b0000010000,
    S_INS  = 10'b0000100000,
    S_DSET = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_DEND = 10'b0100000000,
    S_PW   = 10'b1000000000
  } state_t;

  localparam state_t S_OUT_C = S_LOAD;

  state_t                 state_r, state_nxt;
  logic                   out_pend_r;
  logic [TIME_BITS-1:0]   mem [MAX_SAMPLES];
  logic [TIME_BITS-1:0]   rd_data_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [TIME_BITS-1:0]   wr_data;

  logic [CNT_W-1:0]       cnt_r;
  logic [SUM_W-1:0]       sum_r;
  logic [TIME_BITS-1:0]   min_r, max_r;
  logic                   drop_r;
  logic [CNT_W-1:0]       i_r, j_r;
  logic [TIME_BITS-1:0]   v_r;
  logic [2:0]             sel_r;
  logic [SUM_W-1:0]       dvd_r;
  logic [DV_W-1:0]        dvs_r;
  logic [DV_W:0]          rem_r;
  logic [STEP_W-1:0]      step_r;
  logic [TIME_BITS-1:0]   mean_r;
  logic [TIME_BITS-1:0]   pct_r [PCT_NUM];
  logic                   out_tvalid_r;
  logic [OUT_W-1:0]       out_tdata_r;

  logic                   in_acc;
  logic                   has_room;
  logic [TIME_BITS-1:0]   t_in;
  logic [DV_W:0]          shifted;
  logic                   ge;
  logic [CNT_W-1:0]       cnt_m1;
  logic [PROD_W-1:0]      prod;
  logic [QW-1:0]          q_full;
  logic [1:0]             p_idx;
  logic                   out_free;
  logic                   out_load;

  assign in_tready  = (state_r == S_LOAD) && !out_pend_r;
  assign in_acc     = in_tvalid && in_tready;
  assign t_in       = in_tdata[TIME_BITS-1:0];
  assign has_room   = (cnt_r != CNT_W'(MAX_SAMPLES));
  assign shifted    = {rem_r[DV_W-1:0], dvd_r[SUM_W-1]};
  assign ge         = (shifted >= {1'b0, dvs_r});
  assign cnt_m1     = cnt_r - CNT_W'(1);
  assign p_idx      = 2'(sel_r - 3'd1);
  assign prod       = PROD_W'(cnt_m1) * PROD_W'(pct_k(p_idx));
  assign q_full     = QW'(dvd_r[PROD_W-1:0]) * QW'(PCT_RECIP);
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_load   = (state_r == S_LOAD) && out_pend_r && out_free;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = i_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = t_in;
    case (state_r)
      S_LOAD: begin
        wr_en = in_acc && has_room;
        if (in_acc && in_tlast) begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        state_nxt = (i_r >= cnt_r) ? S_DSET : S_RI;
      end
      S_RI: begin
        rd_en     = 1'b1;
        state_nxt = S_VI;
      end
      S_VI: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(i_r - CNT_W'(1));
        state_nxt = S_CMP;
      end
      S_CMP: begin
        wr_en   = 1'b1;
        wr_addr = j_r[AW-1:0];
        if (rd_data_r > v_r) begin
          wr_data = rd_data_r;
          if (j_r == CNT_W'(1)) begin
            state_nxt = S_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(j_r - CNT_W'(2));
          end
        end else begin
          wr_data   = v_r;
          state_nxt = S_SCHK;
        end
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = v_r;
        state_nxt = S_SCHK;
      end
      S_DSET: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if ((sel_r != 3'd0) || (step_r == STEP_W'(1))) begin
          state_nxt = S_DEND;
        end
      end
      S_DEND: begin
        if (sel_r == 3'd0) begin
          state_nxt = S_DSET;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = dvd_r[AW-1:0];
          state_nxt = S_PW;
        end
      end
      S_PW: begin
        state_nxt = (sel_r == 3'(PCT_NUM)) ? S_OUT_C : S_DSET;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      out_pend_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      sum_r        <= '0;
      min_r        <= '1;
      max_r        <= '0;
      drop_r       <= 1'b0;
      i_r          <= '0;
      sel_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (out_pend_r && out_free) begin
            out_tdata_r  <= OUT_W'({drop_r, pct_r[3], pct_r[2], pct_r[1], pct_r[0],
                                    min_r, max_r, mean_r, cnt_r});
            out_pend_r   <= 1'b0;
            cnt_r        <= '0;
            sum_r        <= '0;
            min_r        <= '1;
            max_r        <= '0;
            drop_r       <= 1'b0;
          end else if (in_acc) begin
            if (has_room) begin
              cnt_r <= cnt_r + CNT_W'(1);
              sum_r <= sum_r + SUM_W'(t_in);
              if (t_in < min_r) begin
                min_r <= t_in;
              end
              if (t_in > max_r) begin
                max_r <= t_in;
              end
            end else begin
              drop_r <= 1'b1;
            end
            i_r   <= CNT_W'(1);
            sel_r <= '0;
          end
        end
        S_VI: begin
          v_r <= rd_data_r;
          j_r <= i_r;
        end
        S_CMP: begin
          if (rd_data_r > v_r) begin
            j_r <= j_r - CNT_W'(1);
          end else begin
            i_r <= i_r + CNT_W'(1);
          end
        end
        S_INS: begin
          i_r <= i_r + CNT_W'(1);
        end
        S_DSET: begin
          if (sel_r == 3'd0) begin
            dvd_r <= sum_r;
            dvs_r <= DV_W'(cnt_r);
          end else begin
            dvd_r <= SUM_W'(prod);
          end
          rem_r  <= '0;
          step_r <= STEP_W'(SUM_W);
        end
        S_DIV: begin
          if (sel_r == 3'd0) begin
            rem_r  <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
            dvd_r  <= {dvd_r[SUM_W-2:0], ge};
            step_r <= step_r - STEP_W'(1);
          end else begin
            dvd_r <= SUM_W'(q_full[QW-1:PCT_RECIP_SH]);
          end
        end
        S_DEND: begin
          if (sel_r == 3'd0) begin
            mean_r <= dvd_r[TIME_BITS-1:0];
            sel_r  <= 3'd1;
          end
        end
        S_PW: begin
          pct_r[p_idx] <= rd_data_r;
          sel_r        <= sel_r + 3'd1;
          if (sel_r == 3'(PCT_NUM)) begin
            out_pend_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
